/* src/swm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Shared constants for the sliding window maximum block and its cells.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Default number of cells, which is the longest window the block supports.
  localparam int WINDOW_MAX_DEF  = 64;

  // Default sample width in bits (two's complement).
  localparam int SAMPLE_BITS_DEF = 32;

  // Width of the window length register on the configuration port.
  localparam int CFG_LEN_BITS    = 7;

endpackage

/* src/swm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum cell
// Holds the maximum of the last k+1 samples for its position k in the chain.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [SAMPLE_BITS-1:0] left_max,
  output logic signed [SAMPLE_BITS-1:0] cell_max
);

  logic signed [SAMPLE_BITS-1:0] cell_max_next;

  // The new maximum of this span is the new sample against the shorter span
  // that the left neighbor held before the update.
  always_comb begin
    cell_max_next = (sample_in > left_max) ? sample_in : left_max;
  end

  // Payload register; only written when a sample is taken in.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      cell_max <= cell_max_next;
    end
  end

endmodule

/* src/swm_tap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum output tap
// Picks the cell that matches the window length and folds in the new sample.
// ----------------------------------------------------------------------------
module swm_tap #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int LEN_W       = $clog2(WINDOW_MAX + 1),
  parameter int IDX_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic signed [SAMPLE_BITS-1:0] cells [WINDOW_MAX],
  input  logic        [LEN_W-1:0]       win_len,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] result
);

  logic        [LEN_W-1:0]       sel_full;
  logic        [IDX_W-1:0]       sel;
  logic signed [SAMPLE_BITS-1:0] older_max;

  // The window of length n is the new sample plus the span of n-1 samples
  // held by cell n-2 before this update.
  always_comb begin
    sel_full  = win_len - LEN_W'(2);
    sel       = IDX_W'(sel_full);
    older_max = cells[sel];
    if (win_len == LEN_W'(1)) begin
      result = sample_in;
    end else begin
      result = (sample_in > older_max) ? sample_in : older_max;
    end
  end

endmodule

/* src/sliding_window_maximum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum
// Running maximum of the latest window_len signed samples of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one sample and start_req.
//   A request with start_req set begins a new sequence. Once window_len
//   samples have arrived since the start, every request yields one result
//   on the output channel (out_valid/out_ready): the maximum of the latest
//   window_len samples. Earlier requests yield nothing.
//   The configuration channel (cfg_valid/cfg_ready) writes window_len; a
//   value of 0 acts as 1 and values above WINDOW_MAX saturate. A write also
//   restarts the sequence. Write it only while the block is idle.
//   Throughput is one request per cycle while results are taken: a chain of
//   WINDOW_MAX cells, cell k holding the maximum of the last k+1 samples,
//   shifts once per request. A result is registered in the next cycle.
//   When the receiver stalls with a result waiting, in_ready drops until
//   the result is taken; a result taken in the same cycle frees the slot.
//   Reset sets window_len to 1 and empties the window; cell contents are
//   not cleared since they are only read once refilled.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::CFG_LEN_BITS-1:0]     window_len,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 start_req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        window_max
);

  import swm_pkg::*;

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);

  logic                          in_fire;
  logic                          cfg_fire;
  logic [LEN_W-1:0]              win_len;
  logic [LEN_W-1:0]              win_len_next;
  logic [LEN_W-1:0]              fill_count;
  logic [LEN_W-1:0]              fill_count_next;
  logic [LEN_W-1:0]              fill_base;
  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] cells [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] tap_result;

  // Handshakes.
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;

  // Clamp the written window length into the supported range.
  always_comb begin
    if (window_len == '0) begin
      win_len_next = LEN_W'(1);
    end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
      win_len_next = LEN_W'(WINDOW_MAX);
    end else begin
      win_len_next = LEN_W'(window_len);
    end
  end

  // Fill count of the current sequence, saturating at the window length.
  always_comb begin
    fill_base = start_req ? '0 : fill_count;
    if (fill_base < win_len) begin
      fill_count_next = fill_base + LEN_W'(1);
    end else begin
      fill_count_next = fill_base;
    end
    emit = (fill_count_next == win_len);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len    <= LEN_W'(1);
      fill_count <= '0;
    end else if (cfg_fire) begin
      win_len    <= win_len_next;
      fill_count <= '0;
    end else if (in_fire) begin
      fill_count <= fill_count_next;
    end
  end

  // Chain of cells; cell 0 holds only the newest sample.
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left;
    if (k == 0) begin : g_first
      assign left = sample;
    end else begin : g_rest
      assign left = cells[k-1];
    end
    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .shift_en  (in_fire),
      .sample_in (sample),
      .left_max  (left),
      .cell_max  (cells[k])
    );
  end

  // Tap the span that matches the window length.
  swm_tap #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tap (
    .cells     (cells),
    .win_len   (win_len),
    .sample_in (sample),
    .result    (tap_result)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      window_max <= tap_result;
    end
  end

  // The fill count never runs past the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= win_len)
    else $error("fill count exceeds window length");

  // A start request with a window of one gives a result at once.
  a_len_one: assert property (@(posedge clk) disable iff (rst)
    in_fire && start_req && (win_len == LEN_W'(1)) |=> out_valid)
    else $error("window of one did not produce a result");

  // A configuration write restarts the sequence.
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> fill_count == '0)
    else $error("configuration write did not clear the window");

  // No sample is taken while a result waits on a stalled receiver.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_fire)
    else $error("request taken while output is stalled");

  // A full window yields a result for every request.
  a_full_emit: assert property (@(posedge clk) disable iff (rst)
    in_fire && !start_req && (fill_count == win_len) |=> out_valid)
    else $error("full window request gave no result");

endmodule
